>>> src/key_matrix_drive_strobe_scanner_defines.svh
// Assertion macros for the key matrix drive and strobe scanner.
// Used by RTL files that carry concurrent assertions; expects aclk and aresetn in scope.
`ifndef KEY_MATRIX_DRIVE_STROBE_SCANNER_DEFINES_SVH
`define KEY_MATRIX_DRIVE_STROBE_SCANNER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define KMDS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define KMDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/kmds_pkg.sv
// Shared types, constants and helper functions of the key matrix scanner.
// No dependencies; imported by every module of the block.
package kmds_pkg;

    localparam int unsigned KEY_W      = 8;
    localparam int unsigned PHASE_W    = 8;
    localparam int unsigned DRIVE_W    = 8;
    localparam int unsigned STROBE_W   = 3;
    localparam int unsigned START_W    = 7;
    localparam int unsigned TAIL_W     = 7;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    // Cycle end is start + 3 + tail and needs one bit more than the phase.
    localparam int unsigned END_W      = PHASE_W + 1;

    localparam logic [KEY_W-1:0]    LAST_KEY_RST     = 8'd99;
    localparam logic [START_W-1:0]  PULL_TICK_RST    = 7'd12;
    localparam logic [TAIL_W-1:0]   TAIL_TICKS_RST   = 7'd12;
    localparam logic [DRIVE_W-1:0]  DRIVE_INIT       = 8'h04;
    localparam logic [PHASE_W-1:0]  PHASE_LOAD       = 8'd1;

    // Strobe output codes.
    localparam logic [STROBE_W-1:0] STROBE_LOW   = 3'd0;
    localparam logic [STROBE_W-1:0] STROBE_SETUP = 3'd3;
    localparam logic [STROBE_W-1:0] STROBE_IDLE  = 3'd4;
    localparam logic [STROBE_W-1:0] STROBE_HIGH  = 3'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAST_KEY     = 2'd0,
        REG_PULL_TICK    = 2'd1,
        REG_TAIL_TICKS   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [KEY_W-1:0]   last_key;
        logic [START_W-1:0] pull_tick;
        logic [TAIL_W-1:0]  tail_ticks;
    } cfg_t;

    typedef struct packed {
        logic [DRIVE_W-1:0]  drive_value;
        logic                drive_load;
        logic [STROBE_W-1:0] strobe_level;
        logic                sample_valid;
        logic [KEY_W-1:0]    key_index;
        logic                key_released;
    } res_t;

    // Advance the drive code: column nibble visits 4, 5 and 8..15, row carries.
    function automatic logic [DRIVE_W-1:0] next_drive(input logic [DRIVE_W-1:0] d);
        logic [DRIVE_W-1:0] inc;
        inc = d + 8'd1;
        if (inc[3:0] == 4'h6) begin
            next_drive = inc + 8'd2;
        end else if (inc[3:0] == 4'h0) begin
            next_drive = inc + 8'd4;
        end else begin
            next_drive = inc;
        end
    endfunction

endpackage

>>> src/key_matrix_drive_strobe_scanner.sv
// Key matrix drive and strobe scanner, top level.
// Depends on kmds_pkg, kmds_core and kmds_skid.
//
// Usage:
//   Each transaction on the s_ channel is one timer tick carrying the sensed
//   pin level (s_sense_high). For every tick the block returns exactly one
//   transaction on the m_ channel: the drive code, the drive load flag, the
//   strobe level after this tick, and on the sampling tick the key index and
//   the released flag.
//   Configuration goes over the cfg_ channel (index 0 last key, 1 strobe
//   pull tick, 2 tail ticks); cfg_ready is always high and other
//   indexes are dropped. Write it only while no tick is in flight.
// Timing:
//   A tick's result is registered in kmds_skid (its skid register while the
//   sink stalls). Throughput is one tick per cycle while s_ready is high, set
//   by the single next-state pass in kmds_core between the scan registers.
// Reset (aresetn low, synchronous): phase 0, key 0, drive code 4, strobe 0,
//   registers 99/12/12, no result pending.
// Stall: while m_ready is low the result holds; one more tick is taken into
//   the skid stage, then s_ready drops until the sink takes a result.
module key_matrix_drive_strobe_scanner (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Tick input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_sense_high,
    // Result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [kmds_pkg::DRIVE_W-1:0]        m_drive_value,
    output logic                                m_drive_load,
    output logic [kmds_pkg::STROBE_W-1:0]       m_strobe_level,
    output logic                                m_sample_valid,
    output logic [kmds_pkg::KEY_W-1:0]          m_key_index,
    output logic                                m_key_released,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kmds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kmds_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import kmds_pkg::*;

    cfg_t cfg_reg;
    res_t tick_res;
    res_t out_res;
    logic tick_fire;

    assign cfg_ready = 1'b1;
    assign tick_fire = s_valid && s_ready;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.last_key   <= LAST_KEY_RST;
            cfg_reg.pull_tick  <= PULL_TICK_RST;
            cfg_reg.tail_ticks <= TAIL_TICKS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LAST_KEY:   cfg_reg.last_key   <= cfg_data;
                REG_PULL_TICK:  cfg_reg.pull_tick  <= cfg_data[START_W-1:0];
                REG_TAIL_TICKS: cfg_reg.tail_ticks <= cfg_data[TAIL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Advance the scan on every accepted tick.
    kmds_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_fire  (tick_fire),
        .sense_high (s_sense_high),
        .cfg        (cfg_reg),
        .res        (tick_res)
    );

    // Hold results for the sink; absorb one extra tick when it stalls.
    kmds_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (tick_res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    assign m_drive_value  = out_res.drive_value;
    assign m_drive_load   = out_res.drive_load;
    assign m_strobe_level = out_res.strobe_level;
    assign m_sample_valid = out_res.sample_valid;
    assign m_key_index    = out_res.key_index;
    assign m_key_released = out_res.key_released;

endmodule

>>> src/kmds_core.sv
// Scan sequencer: phase counter, key counter, drive code and strobe registers.
// Depends on kmds_pkg and key_matrix_drive_strobe_scanner_defines.svh.
`include "key_matrix_drive_strobe_scanner_defines.svh"

module kmds_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           tick_fire,
    input  logic           sense_high,
    input  kmds_pkg::cfg_t cfg,
    output kmds_pkg::res_t res
);
    import kmds_pkg::*;

    logic [PHASE_W-1:0]  phase_reg,  phase_next;
    logic [KEY_W-1:0]    key_reg,    key_next;
    logic [DRIVE_W-1:0]  drive_reg,  drive_next;
    logic [STROBE_W-1:0] strobe_reg, strobe_next;

    logic [PHASE_W-1:0]  phase_inc;
    logic [END_W-1:0]    phase_ext;
    logic [END_W-1:0]    start_ext;
    logic [END_W-1:0]    slot_end;
    logic                key_wrap;
    logic                wrap_fire;
    logic                scan_home;

    assign phase_inc = phase_reg + 8'd1;
    assign phase_ext = {1'b0, phase_inc};
    assign start_ext = {{(END_W-START_W){1'b0}}, cfg.pull_tick};
    assign slot_end  = start_ext + 9'd3 + {{(END_W-TAIL_W){1'b0}}, cfg.tail_ticks};
    assign key_wrap  = (key_reg >= cfg.last_key);
    assign wrap_fire = tick_fire && res.sample_valid && key_wrap;
    assign scan_home = (key_reg == '0) && (drive_reg == DRIVE_INIT);

    always_comb begin
        key_next         = key_reg;
        drive_next       = drive_reg;
        strobe_next      = strobe_reg;
        res.drive_value  = drive_reg;
        res.drive_load   = 1'b0;
        res.sample_valid = 1'b0;
        res.key_index    = '0;
        res.key_released = 1'b0;
        // First matching slot position wins.
        priority if (phase_inc == PHASE_LOAD) begin
            res.drive_load = 1'b1;
            strobe_next    = STROBE_IDLE;
        end else if (phase_ext == start_ext) begin
            strobe_next = STROBE_LOW;
        end else if (phase_ext == start_ext + 9'd1) begin
            strobe_next = STROBE_SETUP;
        end else if (phase_ext == start_ext + 9'd2) begin
            res.sample_valid = 1'b1;
            res.key_index    = key_reg;
            res.key_released = ~sense_high;
            if (key_wrap) begin
                key_next   = '0;
                drive_next = DRIVE_INIT;
            end else begin
                key_next   = key_reg + 8'd1;
                drive_next = next_drive(drive_reg);
            end
        end else if (phase_ext == start_ext + 9'd3) begin
            strobe_next = STROBE_HIGH;
        end else if (phase_ext == start_ext + 9'd4) begin
            strobe_next = STROBE_IDLE;
        end else begin
            // Hold the strobe between steps.
        end
        res.strobe_level = strobe_next;
        phase_next = (phase_ext == slot_end) ? '0 : phase_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= '0;
            key_reg    <= '0;
            drive_reg  <= DRIVE_INIT;
            strobe_reg <= STROBE_LOW;
        end else if (tick_fire) begin
            phase_reg  <= phase_next;
            key_reg    <= key_next;
            drive_reg  <= drive_next;
            strobe_reg <= strobe_next;
        end
    end

    `KMDS_ASSERT(a_drive_column, drive_reg[3] || (drive_reg[3:1] == 3'b010), "bad column")
    `KMDS_ASSERT_NEXT(a_wrap_restart, wrap_fire, scan_home, "key wrap did not restart")
    `KMDS_ASSERT_NEXT(a_hold_idle, !tick_fire, $stable({phase_reg, key_reg, drive_reg}), "moved")

endmodule

>>> src/kmds_skid.sv
// Result register with a skid stage that takes one more tick while the sink stalls.
// Depends on kmds_pkg for the result record type.
module kmds_skid (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  kmds_pkg::res_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output kmds_pkg::res_t out_data
);
    import kmds_pkg::*;

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_data_reg, out_data_next;
    res_t skid_data_reg, skid_data_next;
    logic in_fire;

    assign in_fire   = in_valid && in_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && !out_ready) begin
            // Sink stalled: park a new transaction in the skid stage.
            if (in_fire) begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end else if (skid_valid_reg) begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end else begin
            out_valid_next = in_fire;
            out_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule
